/* hdl/gscr_pkg.sv */
// Package for the gap-synced frame change reporter: table, widths and reset values.
package gscr_pkg;

  // Default frame length and gap threshold after reset
  localparam int          FRAME_BITS_DEF  = 32;
  localparam logic [15:0] GAP_THR_RESET   = 16'd2000;

  // Counter sits this far past the frame end while idle
  localparam int          IDLE_MARGIN     = 10;

  // Mapped indicators, scanned in this order
  localparam int          IND_COUNT       = 12;
  localparam int          IND_IDX_W       = $clog2(IND_COUNT);

  // Wide view of a frame for table lookups
  localparam int          FRAME_EXT_W     = 64;

  // Port packing widths
  localparam int          IN_DATA_W       = 24;
  localparam int          OUT_DATA_W      = 16;

  // Frame bit of each indicator
  localparam logic [4:0] IND_BIT [IND_COUNT] = '{
    5'd31, 5'd29, 5'd27, 5'd25, 5'd15, 5'd13, 5'd11, 5'd9,
    5'd19, 5'd21, 5'd17, 5'd23
  };

  // Indicator slot of each indicator
  localparam logic [4:0] IND_SLOT [IND_COUNT] = '{
    5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
    5'd17, 5'd18, 5'd19, 5'd20
  };

endpackage

/* hdl/gap_synced_frame_change_reporter.sv */
// Top level: clock-edge frame receiver that reports indicator changes per frame.
//
//   channel | direction | contents
//   in_     | slave     | tdata = gap_us[15:0], clk_level[16], data_level[17]
//   out_    | master    | tdata = led_slot[4:0], frame_bit[9:5], level[10]; tlast = last
//   cfg_    | write     | cfg_wdata = gap_threshold_us
//
// An edge transaction is taken whenever the block is idle. An edge that completes a
// frame with a changed indicator starts a scan of the indicator table, one entry per
// cycle through a single compare/select step, except that a changed entry waits while
// the output is stalled; in_tready is low during the scan. The scan ends at the last
// changed entry. The output register holds a result while the next edge is taken.
// Reset (rst_n low, synchronous) clears the counter to idle and both frames to zero.
module gap_synced_frame_change_reporter #(
  parameter int FRAME_BITS = gscr_pkg::FRAME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Edge channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [gscr_pkg::IN_DATA_W-1:0]  in_tdata,   // gap_us[15:0], clk_level, data_level
  // Change report channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [gscr_pkg::OUT_DATA_W-1:0] out_tdata,  // led_slot[4:0], frame_bit[9:5], level
  output logic                            out_tlast,
  // Gap threshold register
  input  logic                            cfg_wen,
  input  logic [15:0]                     cfg_wdata
);
  import gscr_pkg::*;

  localparam int PW = $clog2(FRAME_BITS + IDLE_MARGIN + 1);
  localparam logic [PW-1:0] IDLE_POS = PW'(FRAME_BITS + IDLE_MARGIN);
  localparam logic [PW-1:0] END_POS  = PW'(FRAME_BITS);
  localparam logic [IND_IDX_W-1:0] LAST_IDX = IND_IDX_W'(IND_COUNT - 1);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                  state_r, state_nxt;
  logic [15:0]             thr_r, thr_nxt;
  logic                    edge_seen_r, edge_seen_nxt;
  logic                    prior_clk_r, prior_clk_nxt;
  logic [PW-1:0]           pos_r, pos_nxt;
  logic [FRAME_BITS-1:0]   frame_r, frame_nxt;
  logic [FRAME_BITS-1:0]   ref_r, ref_nxt;
  logic [IND_COUNT-1:0]    mask_r, mask_nxt;
  logic [IND_COUNT-1:0]    lvl_r, lvl_nxt;
  logic [IND_IDX_W-1:0]    idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [4:0]              out_slot_r, out_slot_nxt;
  logic [4:0]              out_bit_r, out_bit_nxt;
  logic                    out_lvl_r, out_lvl_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [15:0]             in_gap;
  logic                    in_clk, in_data, in_take;
  logic [PW-1:0]           pos_start, pos_adv;
  logic [FRAME_BITS-1:0]   frame_upd;
  logic [FRAME_EXT_W-1:0]  frame_ext, ref_ext;
  logic [IND_COUNT-1:0]    chg_mask, new_lvl;
  logic                    out_free, rest_any;

  // Unpack the edge transaction
  assign in_gap  = in_tdata[15:0];
  assign in_clk  = in_tdata[16];
  assign in_data = in_tdata[17];
  assign in_tready = (state_r == ST_IDLE);
  assign in_take   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Restart on a long gap, then store the data bit at the counter position
  always_comb begin
    pos_start = (edge_seen_r && (in_gap > thr_r)) ? '0 : pos_r;
    pos_adv   = (pos_start < IDLE_POS) ? pos_start + 1'b1 : pos_start;
    for (int i = 0; i < FRAME_BITS; i++) begin
      frame_upd[i] = (32'(pos_start) == i) ? in_data : frame_r[i];
    end
  end

  // Compare every mapped indicator of the updated frame with the reference
  always_comb begin
    frame_ext = {{(FRAME_EXT_W-FRAME_BITS){1'b0}}, frame_upd};
    ref_ext   = {{(FRAME_EXT_W-FRAME_BITS){1'b0}}, ref_r};
    for (int i = 0; i < IND_COUNT; i++) begin
      new_lvl[i]  = frame_ext[{1'b0, IND_BIT[i]}];
      chg_mask[i] = (32'(IND_BIT[i]) < FRAME_BITS) &&
                    (frame_ext[{1'b0, IND_BIT[i]}] != ref_ext[{1'b0, IND_BIT[i]}]);
    end
  end

  // Any change left after the current table entry
  always_comb begin
    rest_any = 1'b0;
    for (int i = 0; i < IND_COUNT; i++) begin
      if (i > 32'(idx_r) && mask_r[i]) begin
        rest_any = 1'b1;
      end
    end
  end

  // Sequencer: take edges while idle, walk the table after a complete frame
  always_comb begin
    state_nxt     = state_r;
    thr_nxt       = cfg_wen ? cfg_wdata : thr_r;
    edge_seen_nxt = edge_seen_r;
    prior_clk_nxt = prior_clk_r;
    pos_nxt       = pos_r;
    frame_nxt     = frame_r;
    ref_nxt       = ref_r;
    mask_nxt      = mask_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_slot_nxt  = out_slot_r;
    out_bit_nxt   = out_bit_r;
    out_lvl_nxt   = out_lvl_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          edge_seen_nxt = 1'b1;
          prior_clk_nxt = in_clk;
          if ((prior_clk_r == in_clk) && (pos_start != '0)) begin
            // Same clock level mid-frame: abort and park the counter
            pos_nxt = IDLE_POS;
          end else begin
            pos_nxt   = pos_adv;
            frame_nxt = frame_upd;
            if (pos_adv == END_POS) begin
              ref_nxt  = frame_upd;
              mask_nxt = chg_mask;
              lvl_nxt  = new_lvl;
              idx_nxt  = '0;
              if (chg_mask != '0) begin
                state_nxt = ST_SCAN;
              end
            end
          end
        end
      end
      ST_SCAN: begin
        if (mask_r[idx_r]) begin
          // Emit this change once the output register is free
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_slot_nxt  = IND_SLOT[idx_r];
            out_bit_nxt   = IND_BIT[idx_r];
            out_lvl_nxt   = lvl_r[idx_r];
            out_last_nxt  = !rest_any;
            if (!rest_any || idx_r == LAST_IDX) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= GAP_THR_RESET;
      edge_seen_r <= 1'b0;
      prior_clk_r <= 1'b0;
      pos_r       <= IDLE_POS;
      frame_r     <= '0;
      ref_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      edge_seen_r <= edge_seen_nxt;
      prior_clk_r <= prior_clk_nxt;
      pos_r       <= pos_nxt;
      frame_r     <= frame_nxt;
      ref_r       <= ref_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mask_r     <= mask_nxt;
    lvl_r      <= lvl_nxt;
    out_slot_r <= out_slot_nxt;
    out_bit_r  <= out_bit_nxt;
    out_lvl_r  <= out_lvl_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-11){1'b0}}, out_lvl_r, out_bit_r, out_slot_r};

  // A scan only runs right after the counter reached the frame end
  a_scan_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (pos_r == END_POS))
    else $error("scan running with counter off the frame end");

  // A scan always has a change still ahead of it
  a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((mask_r[idx_r]) || rest_any))
    else $error("scan running with no change left");

  // The counter never passes the idle value
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= IDLE_POS)
    else $error("bit counter beyond idle value");

  // Loading the final change of a frame ends the scan
  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && mask_r[idx_r] && out_free && !rest_any) |=> (state_r == ST_IDLE))
    else $error("scan continued after the final change");

endmodule
